>>> rtl/core/min_tracking_stack_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min tracking stack
// Shared helpers that min_tracking_stack.sv uses to write its concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define MTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// Min tracking stack package
// Payload types, cell types, error codes and default constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // Default number of stack cells.
  localparam int DEPTH_DEF = 1024;

  // Field widths fixed by the interface.
  localparam int VAL_W = 32;
  localparam int TOT_W = 11;
  localparam int CAP_W = 11;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Value reported for top and minimum while empty.
  localparam logic signed [VAL_W-1:0] EMPTY_READ = -32'sd1;

  // Operation codes.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // Input transaction.
  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] push_value;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] current_min;
    logic [TOT_W-1:0]        entry_total;
    logic                    is_empty;
    logic [1:0]              error_code;
  } out_t;

  // One stack entry: its value and the minimum up to and including it.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] min;
  } entry_t;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

`default_nettype wire

>>> rtl/core/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// Min tracking stack
// Stack of signed values that reports the running minimum with every result.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on in_valid/in_ready either pushes in_data.push_value
//   or pops the top entry, and yields exactly one result transaction on
//   out_valid/out_ready with the popped value, new top, new minimum, entry
//   count, empty flag and error code.
//   The stack is a row of DEPTH cells; cell 0 is always the top entry, so a
//   push or pop is one shift of the whole row.
//   out_valid rises in the cycle after acceptance. One transaction is
//   taken per cycle, limited by the single output register: in_ready is high
//   whenever that register is empty or is being drained in the same cycle.
//   If the receiver holds out_ready low, the result is held and in_ready drops
//   until it is taken.
//   Reset empties the stack and sets capacity_limit to 1024; no clearing pass
//   runs, the block is ready the cycle after reset is released.
//   capacity_limit sits at byte address 0 of the cfg_ port; the user keeps it
//   written only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "min_tracking_stack_defines.svh"

module min_tracking_stack #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mts_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mts_pkg::out_t      out_data,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [mts_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_nxt;
  logic                      out_valid_r;
  mts_pkg::out_t             out_data_r;
  mts_pkg::out_t             out_data_nxt;

  logic                      in_fire;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      full;
  logic [31:0]               cnt_ext;
  logic signed [mts_pkg::VAL_W-1:0] new_min;
  mts_pkg::shift_t           ctrl;
  mts_pkg::entry_t           new_entry;
  mts_pkg::entry_t           cell_q [DEPTH];

  // Configuration port: index is paddr[2], writes land on the access phase.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= mts_pkg::CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == mts_pkg::REG_CAPACITY)) begin
      cap_r <= cfg_pwdata[mts_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mts_pkg::REG_CAPACITY) begin
      cfg_prdata = 32'(cap_r);
    end
  end

  // Handshake: the output register frees itself when it is drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Full when the count reaches the capacity, saturated to the cell count.
  assign cnt_ext = 32'(cnt_r);
  assign full    = (cnt_ext >= 32'(cap_r)) || (cnt_ext >= 32'(DEPTH));
  assign push_ok = (in_data.mode == mts_pkg::MODE_PUSH) && !full;
  assign pop_ok  = (in_data.mode == mts_pkg::MODE_POP) && (cnt_r != '0);

  // Minimum carried into the new top entry.
  always_comb begin
    new_min = in_data.push_value;
    if ((cnt_r != '0) && (cell_q[0].min < in_data.push_value)) begin
      new_min = cell_q[0].min;
    end
  end

  assign new_entry.value = in_data.push_value;
  assign new_entry.min   = new_min;
  assign ctrl.push       = in_fire && push_ok;
  assign ctrl.pop        = in_fire && pop_ok;

  // Row of cells, cell 0 holding the top of the stack.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mts_pkg::entry_t above;
    mts_pkg::entry_t below;
    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_inner
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_upper
      assign below = cell_q[i+1];
    end
    mts_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .entry_q    (cell_q[i])
    );
  end

  // Result of the accepted transaction.
  always_comb begin
    cnt_nxt      = cnt_r;
    out_data_nxt = '0;
    out_data_nxt.error_code = mts_pkg::ERR_OK;
    if (in_data.mode == mts_pkg::MODE_PUSH) begin
      if (push_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        out_data_nxt.top_value   = in_data.push_value;
        out_data_nxt.current_min = new_min;
      end else begin
        out_data_nxt.error_code  = mts_pkg::ERR_FULL;
        out_data_nxt.top_value   = (cnt_r == '0) ? mts_pkg::EMPTY_READ : cell_q[0].value;
        out_data_nxt.current_min = (cnt_r == '0) ? mts_pkg::EMPTY_READ : cell_q[0].min;
      end
    end else begin
      if (pop_ok) begin
        cnt_nxt = cnt_r - CNT_W'(1);
        out_data_nxt.popped_value = cell_q[0].value;
        out_data_nxt.top_value    = (cnt_nxt == '0) ? mts_pkg::EMPTY_READ : cell_q[1].value;
        out_data_nxt.current_min  = (cnt_nxt == '0) ? mts_pkg::EMPTY_READ : cell_q[1].min;
      end else begin
        out_data_nxt.error_code  = mts_pkg::ERR_EMPTY;
        out_data_nxt.top_value   = mts_pkg::EMPTY_READ;
        out_data_nxt.current_min = mts_pkg::EMPTY_READ;
      end
    end
    out_data_nxt.entry_total = mts_pkg::TOT_W'(cnt_nxt);
    out_data_nxt.is_empty    = (cnt_nxt == '0);
  end

  // Entry count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r <= cnt_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks on the stack bookkeeping.
  `MTS_ASSERT_IMP(a_cnt_in_range, 1'b1, 32'(cnt_r) <= 32'(DEPTH), "entry count exceeds depth")
  `MTS_ASSERT_NXT(a_push_lands_on_top, in_fire && push_ok, cell_q[0].value == $past(in_data.push_value), "pushed value not on top")
  `MTS_ASSERT_NXT(a_error_keeps_count, in_fire && !push_ok && !pop_ok, cnt_r == $past(cnt_r), "refused transaction changed the count")
  `MTS_ASSERT_IMP(a_empty_reads_neg1, out_valid_r && out_data_r.is_empty, (out_data_r.top_value == mts_pkg::EMPTY_READ) && (out_data_r.current_min == mts_pkg::EMPTY_READ) && (out_data_r.entry_total == '0), "empty result fields wrong")

endmodule

`default_nettype wire

>>> rtl/core/mts_cell.sv
// ----------------------------------------------------------------------------
// Min tracking stack cell
// Holds one entry and shifts toward the bottom on push, toward the top on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_cell (
  input  wire logic            clk,
  input  wire mts_pkg::shift_t ctrl,
  input  wire mts_pkg::entry_t from_above,
  input  wire mts_pkg::entry_t from_below,
  output mts_pkg::entry_t      entry_q
);

  mts_pkg::entry_t entry_r;
  mts_pkg::entry_t entry_nxt;

  // A push takes the neighbor above, a pop the neighbor below.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      entry_nxt = from_above;
    end else if (ctrl.pop) begin
      entry_nxt = from_below;
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

`default_nettype wire

>>> test/min_tracking_stack_tb.sv
// ----------------------------------------------------------------------------
// Min tracking stack testbench
// Drives push and pop transactions under random back-pressure and gaps, and
// compares every result against a scoreboard that keeps its own copy of the
// stack contents, the running minimum and the capacity register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack_tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int REG_STRIDE   = 4;
  // Index with no register behind it; writes there must be ignored.
  localparam int REG_SPARE    = 1;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int MAX_REPORTS  = 50;

  // Scoreboard: mirrors the stack and queues the expected result of every
  // accepted transaction.
  class min_stack_scoreboard;
    logic signed [mts_pkg::VAL_W-1:0] value_mem [mts_pkg::DEPTH_DEF];
    logic signed [mts_pkg::VAL_W-1:0] floor_mem [mts_pkg::DEPTH_DEF];
    int unsigned                      held;
    logic [mts_pkg::CAP_W-1:0]        capacity;
    mts_pkg::out_t                    expected_q [$];
    int                               mismatches;
    int                               checked;
    int                               accepted;
    int                               full_refusals;
    int                               empty_refusals;
    int                               deepest;

    function new();
      held           = 0;
      capacity       = mts_pkg::CAP_RESET;
      mismatches     = 0;
      checked        = 0;
      accepted       = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      deepest        = 0;
    endfunction

    function void write_register(int unsigned index, logic [31:0] data);
      if (index == mts_pkg::REG_CAPACITY) begin
        capacity = data[mts_pkg::CAP_W-1:0];
      end
    endfunction

    // Apply one accepted transaction and queue the result it must produce.
    function void note_input(mts_pkg::in_t item);
      mts_pkg::out_t                    exp;
      int unsigned                      limit;
      logic signed [mts_pkg::VAL_W-1:0] floor_val;
      exp            = '0;
      exp.error_code = mts_pkg::ERR_OK;
      // Capacity saturates at the physical depth.
      limit = (capacity > mts_pkg::DEPTH_DEF) ? mts_pkg::DEPTH_DEF : capacity;
      if (item.mode == mts_pkg::MODE_PUSH) begin
        if (held >= limit) begin
          exp.error_code = mts_pkg::ERR_FULL;
          full_refusals++;
        end else begin
          floor_val = item.push_value;
          if (held > 0 && floor_mem[held-1] < item.push_value) begin
            floor_val = floor_mem[held-1];
          end
          value_mem[held] = item.push_value;
          floor_mem[held] = floor_val;
          held++;
        end
      end else begin
        if (held == 0) begin
          exp.error_code = mts_pkg::ERR_EMPTY;
          empty_refusals++;
        end else begin
          held--;
          exp.popped_value = value_mem[held];
        end
      end
      // An empty stack reads all ones for top and minimum.
      if (held == 0) begin
        exp.top_value   = mts_pkg::EMPTY_READ;
        exp.current_min = mts_pkg::EMPTY_READ;
      end else begin
        exp.top_value   = value_mem[held-1];
        exp.current_min = floor_mem[held-1];
      end
      exp.entry_total = mts_pkg::TOT_W'(held);
      exp.is_empty    = (held == 0);
      if (held > deepest) begin
        deepest = held;
      end
      accepted++;
      expected_q.push_back(exp);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] MISMATCH at result %0d: %s", $time, checked, msg);
      end
    endtask

    // Compare one result transaction with the oldest expectation.
    task check_result(mts_pkg::out_t got);
      mts_pkg::out_t exp;
      if (expected_q.size() == 0) begin
        report("result arrived with no transaction outstanding");
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.popped_value !== exp.popped_value) begin
        report($sformatf("popped_value %0d, expected %0d", got.popped_value,
                         exp.popped_value));
      end
      if (got.top_value !== exp.top_value) begin
        report($sformatf("top_value %0d, expected %0d", got.top_value, exp.top_value));
      end
      if (got.current_min !== exp.current_min) begin
        report($sformatf("current_min %0d, expected %0d", got.current_min,
                         exp.current_min));
      end
      if (got.entry_total !== exp.entry_total) begin
        report($sformatf("entry_total %0d, expected %0d", got.entry_total,
                         exp.entry_total));
      end
      if (got.is_empty !== exp.is_empty) begin
        report($sformatf("is_empty %b, expected %b", got.is_empty, exp.is_empty));
      end
      if (got.error_code !== exp.error_code) begin
        report($sformatf("error_code %0d, expected %0d", got.error_code,
                         exp.error_code));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  mts_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  mts_pkg::out_t out_data;
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [2:0]    cfg_paddr;
  logic [31:0]   cfg_pwdata;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  min_stack_scoreboard              sb = new();
  bit                               calm;
  logic signed [mts_pkg::VAL_W-1:0] last_pushed;
  int                               stall_left;

  min_tracking_stack i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Pause length in cycles: mostly none or short, now and then long.
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 70) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  function automatic mts_pkg::in_t op_push(logic signed [mts_pkg::VAL_W-1:0] value);
    mts_pkg::in_t item;
    item.mode       = mts_pkg::MODE_PUSH;
    item.push_value = value;
    return item;
  endfunction

  function automatic mts_pkg::in_t op_pop();
    mts_pkg::in_t item;
    item.mode       = mts_pkg::MODE_POP;
    item.push_value = $urandom;
    return item;
  endfunction

  // Random transaction. Values favor extremes, repeats and near neighbors so
  // that ties and changes of the minimum come up often.
  function automatic mts_pkg::in_t next_item(int push_pct);
    mts_pkg::in_t item;
    int           pick;
    item.mode = ($urandom_range(0, 99) < push_pct) ? mts_pkg::MODE_PUSH : mts_pkg::MODE_POP;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      item.push_value = $urandom;
    end else if (pick < 60) begin
      item.push_value = $signed($urandom_range(0, 16)) - 8;
    end else if (pick < 72) begin
      case ($urandom_range(0, 3))
        0: item.push_value = 32'h7FFF_FFFF;
        1: item.push_value = 32'h8000_0000;
        2: item.push_value = '0;
        default: item.push_value = '1;
      endcase
    end else if (pick < 88) begin
      item.push_value = last_pushed;
    end else begin
      item.push_value = last_pushed + ($urandom_range(0, 1) ? 1 : -1);
    end
    if (item.mode == mts_pkg::MODE_PUSH) begin
      last_pushed = item.push_value;
    end
    return item;
  endfunction

  // Present one transaction and hold it until the block accepts it.
  task automatic drive_item(input mts_pkg::in_t item);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  task automatic run_random(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      drive_item(next_item(push_pct));
    end
  endtask

  // Stop sending and wait until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access.
  task automatic cfg_write(input int unsigned index, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(index * REG_STRIDE);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_register(index, data);
  endtask

  // Result side: take results under random back-pressure and check them.
  initial begin
    out_ready  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if (stall_left == 0) begin
        stall_left = pick_pause();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    calm        = 1'b0;
    last_pushed = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small capacity: underflow, extremes, a tie on the minimum, overflow.
    cfg_write(mts_pkg::REG_CAPACITY, 3);
    drive_item(op_pop());
    drive_item(op_push(32'h7FFF_FFFF));
    drive_item(op_push(32'h8000_0000));
    drive_item(op_push(32'h8000_0000));
    drive_item(op_push(-1));
    drive_item(op_pop());
    drive_item(op_pop());
    drive_item(op_pop());
    drive_item(op_pop());
    drive_item(op_push(0));
    drive_item(op_push(0));
    drive_item(op_pop());
    drive_item(op_pop());
    drain_results();

    // Zero capacity refuses every push.
    cfg_write(mts_pkg::REG_CAPACITY, 0);
    drive_item(op_push(5));
    drive_item(op_pop());
    drain_results();

    // Capacity above the physical depth behaves as the depth.
    cfg_write(mts_pkg::REG_CAPACITY, 2047);
    drive_item(op_push(5));
    drive_item(op_push(3));
    drive_item(op_push(3));
    drive_item(op_push(9));
    drive_item(op_pop());
    drive_item(op_pop());
    drain_results();

    // A write to an unmapped index must leave the capacity alone.
    cfg_write(REG_SPARE, 0);
    drive_item(op_push(1));
    drive_item(op_pop());
    drive_item(op_pop());
    drive_item(op_pop());
    drain_results();

    // Random phases over a range of capacities.
    cfg_write(mts_pkg::REG_CAPACITY, 16);
    run_random(300, 60);
    drain_results();

    // Capacity lowered below the current count: pops only until it drops.
    cfg_write(mts_pkg::REG_CAPACITY, 4);
    run_random(120, 45);
    drain_results();

    cfg_write(mts_pkg::REG_CAPACITY, 1);
    run_random(80, 50);
    drain_results();

    // Full rate on both sides.
    calm = 1'b1;
    cfg_write(mts_pkg::REG_CAPACITY, 1024);
    run_random(200, 55);
    drain_results();
    calm = 1'b0;

    // Fill to the physical depth, then mix around the top.
    cfg_write(mts_pkg::REG_CAPACITY, 2047);
    run_random(1030, 100);
    run_random(100, 50);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d transactions at capacities 0, 1, 3, 4, 16, 1024 and 2047;",
             sb.accepted);
    $display("deepest stack %0d, %0d full and %0d empty refusals, %0d results checked.",
             sb.deepest, sb.full_refusals, sb.empty_refusals, sb.checked);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
